FILE: rtl/pid_pkg.sv
`timescale 1ns / 1ps

package pid_pkg;

  // Fixed number formats of the controller.
  localparam int SAMPLE_WIDTH       = 16;
  localparam int GAIN_FRAC_BITS     = 8;
  localparam int TIME_WIDTH         = 32;
  localparam int INTEGRAL_FRAC_BITS = 16;

  localparam int GAIN_WIDTH = 16;
  localparam int LIMIT_WIDTH = 15;
  localparam int ERR_WIDTH  = SAMPLE_WIDTH + 1;
  localparam int DIFF_WIDTH = SAMPLE_WIDTH + 2;
  localparam int INT_WIDTH  = 32;
  localparam int INT_SHIFT  = INTEGRAL_FRAC_BITS - GAIN_FRAC_BITS;
  localparam int INC_KEEP   = INT_WIDTH - INT_SHIFT;
  localparam int ACC_WIDTH  = 40;
  localparam int MUL_WIDTH  = 32;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  localparam int DIV_WIDTH  = 33;
  localparam int DIV_CNT_W  = 6;

  localparam int IN_DATA_W  = TIME_WIDTH + 2 * SAMPLE_WIDTH;
  localparam int OUT_DATA_W = SAMPLE_WIDTH;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_SOURCE = 3'd6;

  localparam logic [1:0] DSRC_ERROR    = 2'd0;
  localparam logic [1:0] DSRC_TARGET   = 2'd1;
  localparam logic [1:0] DSRC_MEASURED = 2'd2;

  // Microcode.
  localparam int PC_W = 5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_MUL_P,
    OP_ACC_P,
    OP_MUL_I,
    OP_MUL_T,
    OP_INT,
    OP_ACC_I,
    OP_MUL_D,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_ACC_D,
    OP_EMIT,
    OP_PASS,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_KIND,
    COND_DISABLED,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            done;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_IDLE      = 5'd0;
  localparam logic [PC_W-1:0] PC_KIND      = 5'd1;
  localparam logic [PC_W-1:0] PC_MODE      = 5'd2;
  localparam logic [PC_W-1:0] PC_LOAD      = 5'd3;
  localparam logic [PC_W-1:0] PC_MUL_P     = 5'd4;
  localparam logic [PC_W-1:0] PC_ACC_P     = 5'd5;
  localparam logic [PC_W-1:0] PC_MUL_I     = 5'd6;
  localparam logic [PC_W-1:0] PC_MUL_T     = 5'd7;
  localparam logic [PC_W-1:0] PC_INT       = 5'd8;
  localparam logic [PC_W-1:0] PC_ACC_I     = 5'd9;
  localparam logic [PC_W-1:0] PC_MUL_D     = 5'd10;
  localparam logic [PC_W-1:0] PC_DIV_START = 5'd11;
  localparam logic [PC_W-1:0] PC_DIV_STEP  = 5'd12;
  localparam logic [PC_W-1:0] PC_ACC_D     = 5'd13;
  localparam logic [PC_W-1:0] PC_EMIT      = 5'd14;
  localparam logic [PC_W-1:0] PC_PASS      = 5'd15;
  localparam logic [PC_W-1:0] PC_CLEAR     = 5'd16;

  function automatic ucode_t uword(input op_t op, input cond_t cond,
                                   input logic [PC_W-1:0] target, input logic done);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.done   = done;
    return w;
  endfunction

  // Control store: a taken condition jumps to target, otherwise done returns to
  // the idle step and any other word falls through to the next step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_IDLE:      w = uword(OP_ACCEPT,    COND_NO_INPUT, PC_IDLE,     1'b0);
      PC_KIND:      w = uword(OP_NONE,      COND_KIND,     PC_CLEAR,    1'b0);
      PC_MODE:      w = uword(OP_NONE,      COND_DISABLED, PC_PASS,     1'b0);
      PC_LOAD:      w = uword(OP_LOAD,      COND_NEVER,    PC_IDLE,     1'b0);
      PC_MUL_P:     w = uword(OP_MUL_P,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_ACC_P:     w = uword(OP_ACC_P,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_MUL_I:     w = uword(OP_MUL_I,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_MUL_T:     w = uword(OP_MUL_T,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_INT:       w = uword(OP_INT,       COND_NEVER,    PC_IDLE,     1'b0);
      PC_ACC_I:     w = uword(OP_ACC_I,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_MUL_D:     w = uword(OP_MUL_D,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_DIV_START: w = uword(OP_DIV_START, COND_NEVER,    PC_IDLE,     1'b0);
      PC_DIV_STEP:  w = uword(OP_DIV_STEP,  COND_DIV_BUSY, PC_DIV_STEP, 1'b0);
      PC_ACC_D:     w = uword(OP_ACC_D,     COND_NEVER,    PC_IDLE,     1'b0);
      PC_EMIT:      w = uword(OP_EMIT,      COND_OUT_BUSY, PC_EMIT,     1'b1);
      PC_PASS:      w = uword(OP_PASS,      COND_OUT_BUSY, PC_PASS,     1'b1);
      PC_CLEAR:     w = uword(OP_CLEAR,     COND_NEVER,    PC_IDLE,     1'b1);
      default:      w = uword(OP_NONE,      COND_NEVER,    PC_IDLE,     1'b1);
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/pid_controller_step_unit.sv
`timescale 1ns / 1ps
// Control sample: the load, P, I, integral and D steps run in order, the D term through
// a 33-step restoring divider, and the result is emitted before the next item is taken.
// Disabled loop: the target is passed through as the result before the next item.
// Clear item: no result, the integral is zeroed. A finished result waits in the output
// register while the next item is taken. Synchronous rst restores the register defaults
// and zeroes the integral and all previous-sample state.
module pid_controller_step_unit
  import pid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // timestamp [31:0], measured_value [47:32], target_value [63:48]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // drive [15:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // drive_clamped [0]
  output logic [0:0]            m_axis_tuser
);

  // Sequencer.
  logic [PC_W-1:0] pc, pc_next;
  ucode_t          uw;
  logic            cond_hit;

  // Configuration registers.
  logic                          loop_enabled;
  logic signed [GAIN_WIDTH-1:0]  proportional_gain;
  logic signed [GAIN_WIDTH-1:0]  integral_gain;
  logic signed [GAIN_WIDTH-1:0]  derivative_gain;
  logic [LIMIT_WIDTH-1:0]        windup_limit;
  logic [LIMIT_WIDTH-1:0]        drive_limit;
  logic [1:0]                    derivative_source;

  // Latched input item.
  logic                           in_kind;
  logic [TIME_WIDTH-1:0]          in_time;
  logic signed [SAMPLE_WIDTH-1:0] in_meas;
  logic signed [SAMPLE_WIDTH-1:0] in_tgt;

  // Controller state.
  logic signed [INT_WIDTH-1:0]    integral_sum, integral_next;
  logic signed [ERR_WIDTH-1:0]    previous_error;
  logic signed [SAMPLE_WIDTH-1:0] previous_target;
  logic signed [SAMPLE_WIDTH-1:0] previous_measured;
  logic [TIME_WIDTH-1:0]          previous_time;

  // Working registers.
  logic [TIME_WIDTH-1:0]      elapsed;
  logic [SAMPLE_WIDTH-1:0]    err_mag;
  logic                       err_neg;
  logic [DIFF_WIDTH-2:0]      diff_mag;
  logic                       diff_neg;
  logic [PROD_WIDTH-1:0]      mul_q;
  logic signed [ACC_WIDTH-1:0] acc;
  logic [TIME_WIDTH-1:0]      div_rem;
  logic [DIV_WIDTH-1:0]       div_quo;
  logic [DIV_CNT_W-1:0]       div_cnt;

  // Output register.
  logic                    m_valid;
  logic [OUT_DATA_W-1:0]   drive_q;
  logic                    clamped_q;
  logic                    out_busy;

  logic xfer_in;

  // Datapath signals.
  logic signed [ERR_WIDTH-1:0]  err_full;
  logic [ERR_WIDTH-1:0]         err_abs;
  logic signed [DIFF_WIDTH-1:0] diff_full;
  logic [DIFF_WIDTH-1:0]        diff_abs;
  logic [GAIN_WIDTH-1:0]        pg_mag, ig_mag, dg_mag;
  logic [MUL_WIDTH-1:0]         mul_a, mul_b;
  logic [PROD_WIDTH-1:0]        mul_p;

  logic                         i_neg;
  logic                         inc_big;
  logic [INT_WIDTH-1:0]         inc_mag;
  logic signed [INT_WIDTH+1:0]  sum_ext, inc_s, sum_new, wlim, wlim_neg;

  logic [ACC_WIDTH-1:0]         p_val, i_val, d_val;
  logic                         p_neg, d_neg;

  logic [DIV_WIDTH-1:0]         div_trial;
  logic                         div_ge;

  logic signed [ACC_WIDTH-GAIN_FRAC_BITS-1:0] res;
  logic signed [ACC_WIDTH-GAIN_FRAC_BITS-1:0] dlim, dlim_neg;
  logic [OUT_DATA_W-1:0]        drive_next;
  logic                         clamped_next;

  assign uw            = ucode_rom(pc);
  assign s_axis_tready = (uw.op == OP_ACCEPT) && !rst;
  assign xfer_in       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_valid && !m_axis_tready;

  assign m_axis_tvalid   = m_valid;
  assign m_axis_tdata    = drive_q;
  assign m_axis_tuser[0] = clamped_q;

  always_comb begin
    case (uw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_NO_INPUT: cond_hit = !s_axis_tvalid;
      COND_KIND:     cond_hit = in_kind;
      COND_DISABLED: cond_hit = !loop_enabled;
      COND_DIV_BUSY: cond_hit = (div_cnt != DIV_CNT_W'(1));
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_next = uw.target;
    end else if (uw.done) begin
      pc_next = PC_IDLE;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  // Error and derivative source, formed in the load step.
  always_comb begin
    err_full = {in_meas[SAMPLE_WIDTH-1], in_meas} - {in_tgt[SAMPLE_WIDTH-1], in_tgt};
    err_abs  = err_full[ERR_WIDTH-1] ? (~err_full + 1'b1) : err_full;
    case (derivative_source)
      DSRC_ERROR:    diff_full = {err_full[ERR_WIDTH-1], err_full}
                               - {previous_error[ERR_WIDTH-1], previous_error};
      DSRC_TARGET:   diff_full = {{2{in_tgt[SAMPLE_WIDTH-1]}}, in_tgt}
                               - {{2{previous_target[SAMPLE_WIDTH-1]}}, previous_target};
      DSRC_MEASURED: diff_full = {{2{in_meas[SAMPLE_WIDTH-1]}}, in_meas}
                               - {{2{previous_measured[SAMPLE_WIDTH-1]}}, previous_measured};
      default:       diff_full = '0;
    endcase
    diff_abs = diff_full[DIFF_WIDTH-1] ? (~diff_full + 1'b1) : diff_full;
  end

  assign pg_mag = proportional_gain[GAIN_WIDTH-1] ? (~proportional_gain + 1'b1)
                                                  : proportional_gain;
  assign ig_mag = integral_gain[GAIN_WIDTH-1] ? (~integral_gain + 1'b1) : integral_gain;
  assign dg_mag = derivative_gain[GAIN_WIDTH-1] ? (~derivative_gain + 1'b1)
                                                : derivative_gain;

  // One shared unsigned multiplier; all products are taken on magnitudes.
  always_comb begin
    case (uw.op)
      OP_MUL_P: begin
        mul_a = MUL_WIDTH'(err_mag);
        mul_b = MUL_WIDTH'(pg_mag);
      end
      OP_MUL_I: begin
        mul_a = MUL_WIDTH'(err_mag);
        mul_b = MUL_WIDTH'(ig_mag);
      end
      OP_MUL_T: begin
        mul_a = mul_q[MUL_WIDTH-1:0];
        mul_b = MUL_WIDTH'(elapsed);
      end
      OP_MUL_D: begin
        mul_a = MUL_WIDTH'(diff_mag);
        mul_b = MUL_WIDTH'(dg_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{MUL_WIDTH{1'b0}}, mul_a} * {{MUL_WIDTH{1'b0}}, mul_b};

  // Integral update. An increment of 2^32 or more always drives the sum into the
  // windup limit, so only its sign matters then.
  always_comb begin
    i_neg    = err_neg ^ integral_gain[GAIN_WIDTH-1];
    inc_big  = |mul_q[PROD_WIDTH-1:INC_KEEP];
    inc_mag  = {mul_q[INC_KEEP-1:0], {INT_SHIFT{1'b0}}};
    sum_ext  = {{2{integral_sum[INT_WIDTH-1]}}, integral_sum};
    inc_s    = i_neg ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    sum_new  = sum_ext + inc_s;
    wlim     = $signed({3'b000, windup_limit, {INTEGRAL_FRAC_BITS{1'b0}}});
    wlim_neg = -wlim;
    if (inc_big) begin
      integral_next = i_neg ? wlim_neg[INT_WIDTH-1:0] : wlim[INT_WIDTH-1:0];
    end else if (sum_new > wlim) begin
      integral_next = wlim[INT_WIDTH-1:0];
    end else if (sum_new < wlim_neg) begin
      integral_next = wlim_neg[INT_WIDTH-1:0];
    end else begin
      integral_next = sum_new[INT_WIDTH-1:0];
    end
  end

  assign p_neg = err_neg ^ proportional_gain[GAIN_WIDTH-1];
  assign d_neg = diff_neg ^ derivative_gain[GAIN_WIDTH-1];
  assign p_val = {{(ACC_WIDTH-MUL_WIDTH){1'b0}}, mul_q[MUL_WIDTH-1:0]};
  assign i_val = {{(ACC_WIDTH-INT_WIDTH+INT_SHIFT){integral_sum[INT_WIDTH-1]}},
                  integral_sum[INT_WIDTH-1:INT_SHIFT]};
  assign d_val = {{(ACC_WIDTH-DIV_WIDTH){1'b0}}, div_quo};

  // Restoring division, one quotient bit per step; dividend bits leave div_quo at
  // the top while quotient bits enter at the bottom.
  assign div_trial = {div_rem, div_quo[DIV_WIDTH-1]};
  assign div_ge    = div_trial >= {1'b0, elapsed};

  // Output floor and clamp.
  always_comb begin
    res      = acc[ACC_WIDTH-1:GAIN_FRAC_BITS];
    dlim     = $signed({{(ACC_WIDTH-GAIN_FRAC_BITS-LIMIT_WIDTH){1'b0}}, drive_limit});
    dlim_neg = -dlim;
    if (res > dlim) begin
      drive_next   = dlim[OUT_DATA_W-1:0];
      clamped_next = 1'b1;
    end else if (res < dlim_neg) begin
      drive_next   = dlim_neg[OUT_DATA_W-1:0];
      clamped_next = 1'b1;
    end else begin
      drive_next   = res[OUT_DATA_W-1:0];
      clamped_next = 1'b0;
    end
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enabled      <= 1'b1;
      proportional_gain <= '0;
      integral_gain     <= '0;
      derivative_gain   <= '0;
      windup_limit      <= '1;
      drive_limit       <= '1;
      derivative_source <= DSRC_ERROR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOP_ENABLED:      loop_enabled      <= cfg_data[0];
        REG_PROPORTIONAL_GAIN: proportional_gain <= cfg_data[GAIN_WIDTH-1:0];
        REG_INTEGRAL_GAIN:     integral_gain     <= cfg_data[GAIN_WIDTH-1:0];
        REG_DERIVATIVE_GAIN:   derivative_gain   <= cfg_data[GAIN_WIDTH-1:0];
        REG_WINDUP_LIMIT:      windup_limit      <= cfg_data[LIMIT_WIDTH-1:0];
        REG_DRIVE_LIMIT:       drive_limit       <= cfg_data[LIMIT_WIDTH-1:0];
        REG_DERIVATIVE_SOURCE: derivative_source <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, controller state and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc                <= PC_IDLE;
      integral_sum      <= '0;
      previous_error    <= '0;
      previous_target   <= '0;
      previous_measured <= '0;
      previous_time     <= '0;
      m_valid           <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uw.op == OP_CLEAR) begin
        integral_sum <= '0;
      end else if (uw.op == OP_INT) begin
        integral_sum <= integral_next;
      end
      if (uw.op == OP_LOAD) begin
        previous_error    <= err_full;
        previous_target   <= in_tgt;
        previous_measured <= in_meas;
        previous_time     <= in_time;
      end
      if ((uw.op == OP_EMIT || uw.op == OP_PASS) && !out_busy) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (xfer_in) begin
      in_kind <= s_axis_tuser[0];
      in_time <= s_axis_tdata[TIME_WIDTH-1:0];
      in_meas <= s_axis_tdata[TIME_WIDTH+SAMPLE_WIDTH-1:TIME_WIDTH];
      in_tgt  <= s_axis_tdata[IN_DATA_W-1:TIME_WIDTH+SAMPLE_WIDTH];
    end
    case (uw.op)
      OP_LOAD: begin
        elapsed  <= in_time - previous_time;
        err_mag  <= err_abs[SAMPLE_WIDTH-1:0];
        err_neg  <= err_full[ERR_WIDTH-1];
        diff_mag <= diff_abs[DIFF_WIDTH-2:0];
        diff_neg <= diff_full[DIFF_WIDTH-1];
      end
      OP_MUL_P, OP_MUL_I, OP_MUL_T, OP_MUL_D: begin
        mul_q <= mul_p;
      end
      OP_ACC_P: begin
        acc <= p_neg ? -p_val : p_val;
      end
      OP_ACC_I: begin
        acc <= acc + i_val;
      end
      OP_DIV_START: begin
        div_rem <= '0;
        div_quo <= mul_q[DIV_WIDTH-1:0];
        div_cnt <= DIV_CNT_W'(DIV_WIDTH);
      end
      OP_DIV_STEP: begin
        div_rem <= div_ge ? TIME_WIDTH'(div_trial - {1'b0, elapsed})
                          : div_trial[TIME_WIDTH-1:0];
        div_quo <= {div_quo[DIV_WIDTH-2:0], div_ge};
        div_cnt <= div_cnt - 1'b1;
      end
      OP_ACC_D: begin
        // Zero elapsed time leaves the D term out.
        if (elapsed != '0) begin
          acc <= d_neg ? (acc - d_val) : (acc + d_val);
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          drive_q   <= drive_next;
          clamped_q <= clamped_next;
        end
      end
      OP_PASS: begin
        if (!out_busy) begin
          drive_q   <= in_tgt;
          clamped_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/pid_chk.sv
`timescale 1ns / 1ps
module pid_chk
  import pid_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser
);

  // No result is left pending once reset has been applied.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Items are worked one at a time, so an input transfer closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is at work");

  // A clamped drive is plus or minus a 15-bit limit and never the most negative code.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 16'h8000)
    else $error("clamped drive outside the limit range");

endmodule

bind pid_controller_step_unit pid_chk u_pid_chk (.*);

FILE: tb/sv/pid_controller_step_unit_tb.sv
`timescale 1ns / 1ps

module pid_controller_step_unit_tb;
  import pid_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;
  // The port decodes three index bits, so one index maps to no register.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 50;

  localparam longint unsigned INC_CAP = 64'd1 << 50;

  typedef struct packed {
    logic                           kind;
    logic [TIME_WIDTH-1:0]          timestamp;
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic signed [SAMPLE_WIDTH-1:0] target;
  } sample_item_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] drive;
    logic                    clamped;
  } drive_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  pid_controller_step_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Controller settings as the block holds them.
  logic                    ctl_enabled = 1'b1;
  logic signed [15:0]      ctl_kp = '0;
  logic signed [15:0]      ctl_ki = '0;
  logic signed [15:0]      ctl_kd = '0;
  logic [LIMIT_WIDTH-1:0]  ctl_windup = 15'h7FFF;
  logic [LIMIT_WIDTH-1:0]  ctl_drive_lim = 15'h7FFF;
  logic [1:0]              ctl_dsrc = DSRC_ERROR;

  // Controller state.
  longint                  integ_acc = 0;
  longint                  prev_err = 0;
  longint                  prev_target = 0;
  longint                  prev_measured = 0;
  logic [TIME_WIDTH-1:0]   prev_time = '0;

  sample_item_t  pending_q[$];
  drive_result_t drive_expect_q[$];
  sample_item_t  offered;
  logic [TIME_WIDTH-1:0] gen_time = '0;
  int send_idle_pct = 33;
  int recv_idle_pct = 47;
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned magnitude(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LOOP_ENABLED:      ctl_enabled = data[0];
      REG_PROPORTIONAL_GAIN: ctl_kp = data;
      REG_INTEGRAL_GAIN:     ctl_ki = data;
      REG_DERIVATIVE_GAIN:   ctl_kd = data;
      REG_WINDUP_LIMIT:      ctl_windup = data[LIMIT_WIDTH-1:0];
      REG_DRIVE_LIMIT:       ctl_drive_lim = data[LIMIT_WIDTH-1:0];
      REG_DERIVATIVE_SOURCE: ctl_dsrc = data[1:0];
      default: ;
    endcase
  endfunction

  // Models one accepted item: a clear, a pass-through, or a drive and a state update.
  function automatic void pid_predict(input sample_item_t it);
    logic [TIME_WIDTH-1:0] dt;
    longint unsigned span, mag;
    longint err, meas, tgt, p_term, d_term, diff, inc, lim, ig, total, res;
    logic neg;
    drive_result_t r;
    if (it.kind == KIND_CLEAR) begin
      integ_acc = 0;
      return;
    end
    if (!ctl_enabled) begin
      r.drive   = it.target;
      r.clamped = 1'b0;
      drive_expect_q.push_back(r);
      return;
    end
    dt   = it.timestamp - prev_time;
    span = dt;
    meas = longint'(it.measured);
    tgt  = longint'(it.target);
    err  = meas - tgt;
    p_term = err * longint'(ctl_kp);

    // Integral increment, with its magnitude saturated well beyond any output effect.
    mag = magnitude(err) * magnitude(longint'(ctl_ki));
    neg = (err < 0) != (ctl_ki < 0);
    if (span == 0) mag = 0;
    else if (mag > INC_CAP / span) mag = INC_CAP;
    else mag = mag * span;
    if (mag > (INC_CAP >> INT_SHIFT)) mag = INC_CAP;
    else mag = mag << INT_SHIFT;
    inc = neg ? -longint'(mag) : longint'(mag);
    integ_acc = integ_acc + inc;
    lim = longint'(ctl_windup) << INTEGRAL_FRAC_BITS;
    if (integ_acc > lim) integ_acc = lim;
    if (integ_acc < -lim) integ_acc = -lim;

    case (ctl_dsrc)
      DSRC_ERROR:    diff = err - prev_err;
      DSRC_TARGET:   diff = tgt - prev_target;
      DSRC_MEASURED: diff = meas - prev_measured;
      default:       diff = 0;
    endcase
    d_term = 0;
    if (span != 0 && diff != 0) begin
      mag = (magnitude(diff) * magnitude(longint'(ctl_kd))) / span;
      neg = (diff < 0) != (ctl_kd < 0);
      d_term = neg ? -longint'(mag) : longint'(mag);
    end

    prev_time     = it.timestamp;
    prev_err      = err;
    prev_target   = tgt;
    prev_measured = meas;

    ig    = integ_acc >>> INT_SHIFT;
    total = p_term + d_term + ig;
    res   = total >>> GAIN_FRAC_BITS;
    r.clamped = 1'b0;
    if (res > longint'(ctl_drive_lim)) begin
      res = longint'(ctl_drive_lim);
      r.clamped = 1'b1;
    end
    if (res < -longint'(ctl_drive_lim)) begin
      res = -longint'(ctl_drive_lim);
      r.clamped = 1'b1;
    end
    r.drive = res[SAMPLE_WIDTH-1:0];
    drive_expect_q.push_back(r);
  endfunction

  // Input driver: a new item is offered only once the previous one is transferred.
  always @(posedge clk) begin
    sample_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) pid_predict(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          offered       <= nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.target, nxt.measured, nxt.timestamp};
          s_axis_tuser  <= nxt.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor, with two long hold-offs that back the block up to its input.
  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_expect_q.size() == 0) begin
          $error("unexpected result: drive %0d, drive_clamped %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          errors++;
        end else begin
          want = drive_expect_q.pop_front();
          if (m_axis_tdata !== want.drive) begin
            $error("drive: expected %0d, got %0d", $signed(want.drive), $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser[0] !== want.clamped) begin
            $error("drive_clamped: expected %0d, got %0d", want.clamped, m_axis_tuser[0]);
            errors++;
          end
        end
        results_seen++;
        if (results_seen == 60 || results_seen == 330) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A clear item leaves nothing to wait for, so the block gets its full latency on top.
  // The queues and the valid line are looked at between edges, once all updates of the
  // edge have settled.
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || drive_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sample(input logic kind, input logic [TIME_WIDTH-1:0] ts,
                              input int meas, input int tgt);
    sample_item_t it;
    it.kind      = kind;
    it.timestamp = ts;
    it.measured  = meas[SAMPLE_WIDTH-1:0];
    it.target    = tgt[SAMPLE_WIDTH-1:0];
    pending_q.push_back(it);
  endtask

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic logic [15:0] pick_gain();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return 16'h8000;
    if (roll == 1) return 16'h7FFF;
    if (roll == 2) return 16'h0000;
    if (roll < 15) return 16'(rand_between(-1024, 1024));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_limit();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hFFFF;
    if (roll == 2) return 16'h7FFF;
    if (roll < 6) return 16'($urandom_range(2000));
    return 16'($urandom);
  endfunction

  task automatic pick_setup();
    write_reg(REG_LOOP_ENABLED, ($urandom_range(99) < 85) ? 16'd1 : 16'd0);
    write_reg(REG_PROPORTIONAL_GAIN, pick_gain());
    write_reg(REG_INTEGRAL_GAIN, pick_gain());
    write_reg(REG_DERIVATIVE_GAIN, pick_gain());
    write_reg(REG_WINDUP_LIMIT, pick_limit());
    write_reg(REG_DRIVE_LIMIT, pick_limit());
    write_reg(REG_DERIVATIVE_SOURCE, 16'($urandom_range(3)));
    if ($urandom_range(3) == 0) write_reg(REG_NONE, 16'($urandom));
  endtask

  // Mostly a steadily advancing clock, now and then a stalled or wrapped one; half the
  // samples have small errors and half are full range, with now and then a clear item.
  task automatic queue_random_item();
    int tgt, meas;
    logic [TIME_WIDTH-1:0] gap;
    case ($urandom_range(9))
      0:       gap = '0;
      7:       gap = $urandom_range(100000, 1);
      8:       gap = $urandom;
      9:       gap = $urandom_range(3, 1);
      default: gap = $urandom_range(200, 1);
    endcase
    gen_time = gen_time + gap;
    if ($urandom_range(1) == 1) begin
      tgt  = rand_between(-2000, 2000);
      meas = tgt + rand_between(-300, 300);
    end else begin
      tgt  = $urandom;
      meas = $urandom;
    end
    queue_sample(($urandom_range(99) < 6) ? KIND_CLEAR : KIND_SAMPLE, gen_time, meas, tgt);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: all gains zero, so the drive stays at zero.
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd0, 32767, -32768);
    queue_sample(KIND_CLEAR, 32'd3, 0, 0);
    queue_sample(KIND_SAMPLE, 32'd7, -32768, 32767);
    wait_idle();

    write_reg(REG_LOOP_ENABLED, 16'd1);
    write_reg(REG_PROPORTIONAL_GAIN, 16'h0100);
    write_reg(REG_INTEGRAL_GAIN, 16'h0010);
    write_reg(REG_DERIVATIVE_GAIN, 16'h8000);
    write_reg(REG_WINDUP_LIMIT, 16'd100);
    write_reg(REG_DRIVE_LIMIT, 16'h7FFF);
    write_reg(REG_DERIVATIVE_SOURCE, 16'(DSRC_ERROR));
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd20, 100, 0);
    queue_sample(KIND_SAMPLE, 32'd20, -32768, 32767);
    queue_sample(KIND_SAMPLE, 32'hFFFF_FFF0, 32767, -32768);
    queue_sample(KIND_SAMPLE, 32'd5, 5, 3);
    queue_sample(KIND_CLEAR, 32'hFFFF_FFFF, -1, -1);
    queue_sample(KIND_SAMPLE, 32'd40, 0, 0);
    wait_idle();

    // Most negative gain, largest positive gains, both limits at zero.
    write_reg(REG_PROPORTIONAL_GAIN, 16'h8000);
    write_reg(REG_INTEGRAL_GAIN, 16'h7FFF);
    write_reg(REG_DERIVATIVE_GAIN, 16'h7FFF);
    write_reg(REG_WINDUP_LIMIT, 16'd0);
    write_reg(REG_DRIVE_LIMIT, 16'd0);
    write_reg(REG_DERIVATIVE_SOURCE, 16'(DSRC_TARGET));
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd41, 1000, -1000);
    queue_sample(KIND_SAMPLE, 32'd50, -5, 32767);
    wait_idle();

    // Limits written with all bits set keep only their low fifteen.
    write_reg(REG_WINDUP_LIMIT, 16'hFFFF);
    write_reg(REG_DRIVE_LIMIT, 16'hFFFF);
    write_reg(REG_DERIVATIVE_SOURCE, 16'(DSRC_MEASURED));
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd51, 32767, 0);
    queue_sample(KIND_SAMPLE, 32'd52, -32768, 0);
    wait_idle();

    // The unused derivative source selects no difference at all.
    write_reg(REG_DERIVATIVE_SOURCE, 16'hFFFF);
    write_reg(REG_NONE, 16'h1234);
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd60, 10, 20);
    wait_idle();

    // Pass-through: the clear still zeroes the integral while the loop is off.
    write_reg(REG_LOOP_ENABLED, 16'hFFFE);
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd70, 1, -32768);
    queue_sample(KIND_CLEAR, 32'd70, 0, 0);
    queue_sample(KIND_SAMPLE, 32'd71, 2, 32767);
    wait_idle();

    write_reg(REG_LOOP_ENABLED, 16'd1);
    @(negedge clk);
    queue_sample(KIND_SAMPLE, 32'd80, 3, 4);
    gen_time = 32'd80;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 47;
      end else if (ph < 7) begin
        send_idle_pct = 47;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_setup();
      @(negedge clk);
      repeat (PHASE_ITEMS) queue_random_item();
    end
    wait_idle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pid_pkg.sv
rtl/pid_controller_step_unit.sv
rtl/pid_chk.sv
tb/sv/pid_controller_step_unit_tb.sv
